@@ sv/wlsh_pkg.sv @@
// Shared types and constants for the weighted lag score block.
`timescale 1ns / 1ps

package wlsh_pkg;

    // Q16 unity and the two intermediate steps of the missed-frame metric
    localparam logic [16:0] Q16_ONE        = 17'h10000;
    localparam logic [16:0] Q16_THIRD      = 17'd21845;
    localparam logic [16:0] Q16_TWO_THIRDS = 17'd43690;

    // Metric bounds in input units
    localparam int UI_LO  = 16;
    localparam int UI_HI  = 100;
    localparam int INL_LO = 16;
    localparam int INL_HI = 60;
    localparam int CPU_LO = 32;
    localparam int CPU_HI = 256;
    localparam int DPC_LO = 1280;
    localparam int DPC_HI = 5120;
    localparam int DWM_HI = 3;

    // Divide by a constant as multiply by a rounded-up reciprocal and shift.
    // d * 65536 / 84   = (d << 14) / 21, numerator below 2^21
    localparam int DIV_UI = 21;
    localparam int SH_UI  = 26;
    localparam logic [21:0] M_UI =
        22'(((64'd1 << SH_UI) + 64'(DIV_UI) - 64'd1) / 64'(DIV_UI));
    // d * 65536 / 44   = (d << 14) / 11, numerator below 2^20
    localparam int DIV_INL = 11;
    localparam int SH_INL  = 24;
    localparam logic [20:0] M_INL =
        21'(((64'd1 << SH_INL) + 64'(DIV_INL) - 64'd1) / 64'(DIV_INL));
    // d * 65536 / 224  = (d << 11) / 7, numerator below 2^19
    localparam int DIV_CPU = 7;
    localparam int SH_CPU  = 22;
    localparam logic [19:0] M_CPU =
        20'(((64'd1 << SH_CPU) + 64'(DIV_CPU) - 64'd1) / 64'(DIV_CPU));
    // d * 65536 / 3840 = (d << 8) / 15, numerator below 2^20
    localparam int DIV_DPC = 15;
    localparam int SH_DPC  = 24;
    localparam logic [20:0] M_DPC =
        21'(((64'd1 << SH_DPC) + 64'(DIV_DPC) - 64'd1) / 64'(DIV_DPC));
    // weighted sum / 100, sum below 2^23
    localparam int DIV_SCORE = 100;
    localparam int SH_SCORE  = 30;
    localparam logic [23:0] M_SCORE =
        24'(((64'd1 << SH_SCORE) + 64'(DIV_SCORE) - 64'd1) / 64'(DIV_SCORE));

    // Weights in percent
    localparam logic [4:0] W_UI  = 5'd30;
    localparam logic [4:0] W_DWM = 5'd20;
    localparam logic [4:0] W_INL = 5'd20;
    localparam logic [4:0] W_CPU = 5'd15;
    localparam logic [4:0] W_DPC = 5'd15;

    localparam logic [3:0] SPIKE_MAX = 4'd15;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPIKE_LIMIT = 3'd0;
    localparam logic [2:0] CFG_COOLDOWN    = 3'd1;
    localparam logic [2:0] CFG_SLIGHT      = 3'd2;
    localparam logic [2:0] CFG_LAGGING     = 3'd3;
    localparam logic [2:0] CFG_CRITICAL    = 3'd4;

    typedef enum logic [1:0] {
        LVL_SNAPPY   = 2'd0,
        LVL_SLIGHT   = 2'd1,
        LVL_LAGGING  = 2'd2,
        LVL_CRITICAL = 2'd3
    } t_level;

    typedef struct packed {
        logic [3:0]  spike_limit;
        logic [15:0] cooldown_ms;
        logic [15:0] slight_threshold;
        logic [15:0] lagging_threshold;
        logic [15:0] critical_threshold;
    } t_cfg;

    typedef struct packed {
        logic [15:0] ui_latency_ms;
        logic [31:0] frames_missed_total;
        logic [9:0]  input_latency_ms;
        logic [11:0] cpu_queue_len;
        logic [14:0] dpc_percent;
        logic [47:0] now_ms;
    } t_sample;

    // Normalized metrics, Q16 with unity included
    typedef struct packed {
        logic [16:0] ui;
        logic [16:0] dwm;
        logic [16:0] inl;
        logic [16:0] cpu;
        logic [16:0] dpc;
        logic [47:0] now_ms;
    } t_norm;

    typedef struct packed {
        logic [22:0] sum;
        logic [47:0] now_ms;
    } t_sum;

    typedef struct packed {
        logic [15:0] score;
        logic [47:0] now_ms;
    } t_scored;

endpackage

@@ sv/wlsh_norm.sv @@
// Missed-frame delta and clamp/normalize stage for the five metrics.
`timescale 1ns / 1ps

module wlsh_norm import wlsh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_sample i_sample,
    output logic    o_valid,
    input  logic    i_ready,
    output t_norm   o_norm
);

    logic        r_valid;
    t_norm       r_norm;
    t_norm       n_norm;
    logic [31:0] r_snap;
    logic        w_load;

    logic [31:0] w_delta;
    logic [6:0]  w_d_ui;
    logic [5:0]  w_d_inl;
    logic [7:0]  w_d_cpu;
    logic [11:0] w_d_dpc;
    logic [42:0] w_p_ui;
    logic [40:0] w_p_inl;
    logic [38:0] w_p_cpu;
    logic [40:0] w_p_dpc;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_norm  = r_norm;

    // non-negative delta against the stored count
    assign w_delta = (i_sample.frames_missed_total >= r_snap)
                   ? i_sample.frames_missed_total - r_snap : '0;

    // offsets above the low bound, only used strictly between the bounds
    assign w_d_ui  = i_sample.ui_latency_ms[6:0] - 7'(UI_LO);
    assign w_d_inl = i_sample.input_latency_ms[5:0] - 6'(INL_LO);
    assign w_d_cpu = i_sample.cpu_queue_len[7:0] - 8'(CPU_LO);
    assign w_d_dpc = 12'(i_sample.dpc_percent[12:0] - 13'(DPC_LO));

    // reciprocal multiplies
    assign w_p_ui  = {w_d_ui, 14'd0} * M_UI;
    assign w_p_inl = {w_d_inl, 14'd0} * M_INL;
    assign w_p_cpu = {w_d_cpu, 11'd0} * M_CPU;
    assign w_p_dpc = {w_d_dpc, 8'd0} * M_DPC;

    // clamp at the bounds
    always_comb begin
        n_norm.now_ms = i_sample.now_ms;

        if (i_sample.ui_latency_ms <= 16'(UI_LO)) begin
            n_norm.ui = '0;
        end else if (i_sample.ui_latency_ms >= 16'(UI_HI)) begin
            n_norm.ui = Q16_ONE;
        end else begin
            n_norm.ui = {1'b0, w_p_ui[SH_UI +: 16]};
        end

        if (w_delta == 32'd0) begin
            n_norm.dwm = '0;
        end else if (w_delta == 32'd1) begin
            n_norm.dwm = Q16_THIRD;
        end else if (w_delta < 32'(DWM_HI)) begin
            n_norm.dwm = Q16_TWO_THIRDS;
        end else begin
            n_norm.dwm = Q16_ONE;
        end

        if (i_sample.input_latency_ms <= 10'(INL_LO)) begin
            n_norm.inl = '0;
        end else if (i_sample.input_latency_ms >= 10'(INL_HI)) begin
            n_norm.inl = Q16_ONE;
        end else begin
            n_norm.inl = {1'b0, w_p_inl[SH_INL +: 16]};
        end

        if (i_sample.cpu_queue_len <= 12'(CPU_LO)) begin
            n_norm.cpu = '0;
        end else if (i_sample.cpu_queue_len >= 12'(CPU_HI)) begin
            n_norm.cpu = Q16_ONE;
        end else begin
            n_norm.cpu = {1'b0, w_p_cpu[SH_CPU +: 16]};
        end

        if (i_sample.dpc_percent <= 15'(DPC_LO)) begin
            n_norm.dpc = '0;
        end else if (i_sample.dpc_percent >= 15'(DPC_HI)) begin
            n_norm.dpc = Q16_ONE;
        end else begin
            n_norm.dpc = {1'b0, w_p_dpc[SH_DPC +: 16]};
        end
    end

    // control and snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_snap  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_load) begin
                r_snap <= i_sample.frames_missed_total;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_norm <= n_norm;
        end
    end

endmodule

@@ sv/wlsh_score.sv @@
// Weighted sum and divide-by-100 stages producing the Q16 score.
`timescale 1ns / 1ps

module wlsh_score import wlsh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_norm   i_norm,
    output logic    o_valid,
    input  logic    i_ready,
    output t_scored o_scored
);

    logic        r_a_valid;
    t_sum        r_sum;
    logic        r_b_valid;
    t_scored     r_scored;
    logic        w_a_load;
    logic        w_b_ready;
    logic        w_b_load;
    logic [22:0] w_sum;
    logic [46:0] w_prod;
    logic [16:0] w_quot;

    assign w_b_ready = !r_b_valid || i_ready;
    assign o_ready   = !r_a_valid || w_b_ready;
    assign w_a_load  = i_valid && o_ready;
    assign w_b_load  = r_a_valid && w_b_ready;
    assign o_valid   = r_b_valid;
    assign o_scored  = r_scored;

    // weights are small constants: shift-and-add
    assign w_sum = W_UI * i_norm.ui + W_DWM * i_norm.dwm + W_INL * i_norm.inl
                 + W_CPU * i_norm.cpu + W_DPC * i_norm.dpc;

    // divide by 100, then saturate the full-scale case
    assign w_prod = r_sum.sum * M_SCORE;
    assign w_quot = w_prod[SH_SCORE +: 17];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_load) begin
            r_sum.sum    <= w_sum;
            r_sum.now_ms <= i_norm.now_ms;
        end
        if (w_b_load) begin
            r_scored.score  <= w_quot[16] ? 16'hFFFF : w_quot[15:0];
            r_scored.now_ms <= r_sum.now_ms;
        end
    end

endmodule

@@ sv/wlsh_hyst.sv @@
// Level mapping, hysteresis state and the result register.
`timescale 1ns / 1ps

module wlsh_hyst import wlsh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_scored     i_scored,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_score,
    output logic [1:0]  o_level,
    output logic        o_changed
);

    logic        r_valid;
    logic [15:0] r_score;
    logic        r_changed;
    t_level      r_held;
    t_level      n_held;
    logic [3:0]  r_cnt;
    logic [3:0]  n_cnt;
    logic [47:0] r_lct;
    logic [47:0] n_lct;
    t_level      w_raw;
    logic        w_changed;
    logic        w_load;
    logic [3:0]  w_cnt_inc;
    logic [47:0] w_elapsed;

    assign o_ready   = !r_valid || i_ready;
    assign w_load    = i_valid && o_ready;
    assign o_valid   = r_valid;
    assign o_score   = r_score;
    assign o_level   = r_held;
    assign o_changed = r_changed;

    // raw level, critical tested first
    always_comb begin
        if (i_scored.score >= i_cfg.critical_threshold) begin
            w_raw = LVL_CRITICAL;
        end else if (i_scored.score >= i_cfg.lagging_threshold) begin
            w_raw = LVL_LAGGING;
        end else if (i_scored.score >= i_cfg.slight_threshold) begin
            w_raw = LVL_SLIGHT;
        end else begin
            w_raw = LVL_SNAPPY;
        end
    end

    assign w_cnt_inc = (r_cnt < SPIKE_MAX) ? r_cnt + 4'd1 : r_cnt;
    assign w_elapsed = i_scored.now_ms - r_lct;

    // hysteresis: spikes counted up, relaxing gated by cooldown
    always_comb begin
        n_held    = r_held;
        n_cnt     = r_cnt;
        n_lct     = r_lct;
        w_changed = 1'b0;
        if (w_raw > r_held) begin
            if (w_cnt_inc >= i_cfg.spike_limit) begin
                n_held    = w_raw;
                n_lct     = i_scored.now_ms;
                n_cnt     = '0;
                w_changed = 1'b1;
            end else begin
                n_cnt = w_cnt_inc;
            end
        end else if (w_raw < r_held) begin
            n_cnt = '0;
            if (w_elapsed >= 48'(i_cfg.cooldown_ms)) begin
                n_held    = w_raw;
                n_lct     = i_scored.now_ms;
                w_changed = 1'b1;
            end
        end else begin
            n_lct = i_scored.now_ms;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_held  <= LVL_SNAPPY;
            r_cnt   <= '0;
            r_lct   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (w_load) begin
                r_held <= n_held;
                r_cnt  <= n_cnt;
                r_lct  <= n_lct;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_score   <= i_scored.score;
            r_changed <= w_changed;
        end
    end

    // a reported change really moved the held level
    a_change_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_changed |=> r_held != $past(r_held))
        else $error("level change flagged but held level unchanged");

    // without a change flag the held level stays put
    a_hold_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && !w_changed |=> r_held == $past(r_held))
        else $error("held level moved without a change flag");

    // accepting a new level always restarts the spike count
    a_change_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_changed |=> r_cnt == 4'd0)
        else $error("spike counter not cleared on level change");

    // a relaxing step is only taken once the cooldown has run
    a_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_changed && (w_raw < r_held) |->
        w_elapsed >= 48'(i_cfg.cooldown_ms))
        else $error("level relaxed before cooldown elapsed");

endmodule

@@ sv/weighted_lag_score_hysteresis.sv @@
// Top level: ports, configuration registers, input register and stage chain.
`timescale 1ns / 1ps

// Weighted lag score with hysteresis. Each input word is one sample of five
// health metrics plus a millisecond timestamp; each produces exactly one
// result word with the Q16 score, the held severity level and a change flag.
// The datapath is a five-register pipeline (input, normalize, weighted sum,
// divide by 100, hysteresis/result), and a new sample can be taken every
// cycle as long as the result stream does not stall the chain; the
// per-sample state (missed-frame snapshot, held level, spike count, last
// change time) closes its loop inside a single stage, so consecutive samples
// never wait on each other. Stages with no word in them accept even while
// the result register is stalled. Configuration writes are taken in any
// cycle and are meant to be made while the pipeline is empty.
module weighted_lag_score_hysteresis import wlsh_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // sample stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [15:0] ui_latency_ms, [47:16] frames_missed_total,
    // [57:48] input_latency_ms, [69:58] cpu_queue_len,
    // [84:70] dpc_percent, [132:85] now_ms, [135:133] zero
    input  logic [135:0] i_s_tdata,
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [15:0] score, [17:16] level, [18] level_changed, [23:19] zero
    output logic [23:0]  o_m_tdata,
    // configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam logic [3:0]  RST_SPIKE_LIMIT = 4'd3;
    localparam logic [15:0] RST_COOLDOWN    = 16'd2000;
    localparam logic [15:0] RST_SLIGHT      = 16'd9830;
    localparam logic [15:0] RST_LAGGING     = 16'd22938;
    localparam logic [15:0] RST_CRITICAL    = 16'd42598;

    t_cfg        r_cfg;
    logic        r_in_valid;
    t_sample     r_in;
    t_sample     w_sample;
    logic        w_in_load;
    logic        w_norm_ready;
    logic        w_norm_valid;
    t_norm       w_norm;
    logic        w_score_ready;
    logic        w_score_valid;
    t_scored     w_scored;
    logic        w_hyst_ready;
    logic [15:0] w_score;
    logic [1:0]  w_level;
    logic        w_changed;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spike_limit        <= RST_SPIKE_LIMIT;
            r_cfg.cooldown_ms        <= RST_COOLDOWN;
            r_cfg.slight_threshold   <= RST_SLIGHT;
            r_cfg.lagging_threshold  <= RST_LAGGING;
            r_cfg.critical_threshold <= RST_CRITICAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPIKE_LIMIT: r_cfg.spike_limit        <= i_cfg_data[3:0];
                CFG_COOLDOWN:    r_cfg.cooldown_ms        <= i_cfg_data;
                CFG_SLIGHT:      r_cfg.slight_threshold   <= i_cfg_data;
                CFG_LAGGING:     r_cfg.lagging_threshold  <= i_cfg_data;
                CFG_CRITICAL:    r_cfg.critical_threshold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // unpack the input word
    assign w_sample.ui_latency_ms       = i_s_tdata[15:0];
    assign w_sample.frames_missed_total = i_s_tdata[47:16];
    assign w_sample.input_latency_ms    = i_s_tdata[57:48];
    assign w_sample.cpu_queue_len       = i_s_tdata[69:58];
    assign w_sample.dpc_percent         = i_s_tdata[84:70];
    assign w_sample.now_ms              = i_s_tdata[132:85];

    // input register
    assign o_s_tready = !r_in_valid || w_norm_ready;
    assign w_in_load  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load) begin
            r_in <= w_sample;
        end
    end

    wlsh_norm u_norm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .o_ready  (w_norm_ready),
        .i_sample (r_in),
        .o_valid  (w_norm_valid),
        .i_ready  (w_score_ready),
        .o_norm   (w_norm)
    );

    wlsh_score u_score (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_norm_valid),
        .o_ready  (w_score_ready),
        .i_norm   (w_norm),
        .o_valid  (w_score_valid),
        .i_ready  (w_hyst_ready),
        .o_scored (w_scored)
    );

    wlsh_hyst u_hyst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (w_score_valid),
        .o_ready   (w_hyst_ready),
        .i_scored  (w_scored),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_score   (w_score),
        .o_level   (w_level),
        .o_changed (w_changed)
    );

    // pack the result word
    assign o_m_tdata = {5'd0, w_changed, w_level, w_score};

endmodule
